// File: rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants for the sphere frustum cull block
// Command and mode codes, plane record, and the queue entry passed from the
// front (decode) to the back (plane sweep).
// ----------------------------------------------------------------------------
package sfc_pkg;

	// Default configuration
	localparam int NUM_PLANES_DEF  = 6;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Field widths fixed by the interface
	localparam int COORD_W  = 32;
	localparam int RADIUS_W = 31;
	localparam int PIDX_W   = 3;
	localparam int MODE_W   = 2;
	localparam int PROD_W   = 2 * COORD_W;
	// Distance accumulator: three 64-bit products plus offset and threshold
	localparam int ACC_W    = PROD_W + 4;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	// Test mode codes
	localparam logic [MODE_W-1:0] MODE_POINT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FULLY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PARTLY = 2'd2;

	// One stored frustum plane
	typedef struct packed {
		logic signed [COORD_W-1:0] nx;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] nz;
		logic signed [COORD_W-1:0] d;
	} plane_t;

	// Decoded request held in the queue between front and back.
	// For a load, a/b/c/d carry the plane; for a test, a/b/c carry the point.
	typedef struct packed {
		logic                      is_test;
		logic                      idx_ok;
		logic [PIDX_W-1:0]         idx;
		logic signed [COORD_W-1:0] a;
		logic signed [COORD_W-1:0] b;
		logic signed [COORD_W-1:0] c;
		logic signed [COORD_W-1:0] d;
		logic signed [ACC_W-1:0]   thr;
		logic                      force_pass;
	} entry_t;

endpackage

// File: rtl/sfc_front.sv
// ----------------------------------------------------------------------------
// sfc_front: request decode and queue
// Classifies each request (load or test), forms the test threshold from the
// radius and mode, flags the infinite-radius case, and queues the result.
// ----------------------------------------------------------------------------
module sfc_front #(
	parameter int NUM_PLANES  = sfc_pkg::NUM_PLANES_DEF,
	parameter int FRAC_BITS   = sfc_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = sfc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                command,
	input  logic [sfc_pkg::PIDX_W-1:0]          plane_index,
	input  logic signed [sfc_pkg::COORD_W-1:0]  normal_x,
	input  logic signed [sfc_pkg::COORD_W-1:0]  normal_y,
	input  logic signed [sfc_pkg::COORD_W-1:0]  normal_z,
	input  logic signed [sfc_pkg::COORD_W-1:0]  plane_offset,
	input  logic signed [sfc_pkg::COORD_W-1:0]  point_x,
	input  logic signed [sfc_pkg::COORD_W-1:0]  point_y,
	input  logic signed [sfc_pkg::COORD_W-1:0]  point_z,
	input  logic [sfc_pkg::RADIUS_W-1:0]        radius,
	input  logic [sfc_pkg::MODE_W-1:0]          test_mode,
	output logic                                head_valid,
	output sfc_pkg::entry_t                     head,
	input  logic                                pop
);

	localparam int QP_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sfc_pkg::entry_t                  dec;
	logic signed [sfc_pkg::ACC_W-1:0] r_wide;
	logic                             push;
	logic                             full;

	sfc_pkg::entry_t  mem_q [QUEUE_DEPTH];
	logic [QP_W-1:0]  wr_ptr_q;
	logic [QP_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Decode the request and build the mode threshold
	always_comb begin
		r_wide         = sfc_pkg::ACC_W'(radius) << FRAC_BITS;
		dec.is_test    = (command == sfc_pkg::CMD_TEST);
		dec.idx_ok     = (int'(plane_index) < NUM_PLANES);
		dec.idx        = plane_index;
		dec.a          = dec.is_test ? point_x : normal_x;
		dec.b          = dec.is_test ? point_y : normal_y;
		dec.c          = dec.is_test ? point_z : normal_z;
		dec.d          = plane_offset;
		dec.force_pass = (test_mode == sfc_pkg::MODE_PARTLY) && (radius == '1);
		case (test_mode)
			sfc_pkg::MODE_FULLY:  dec.thr = r_wide;
			sfc_pkg::MODE_PARTLY: dec.thr = -r_wide;
			default:              dec.thr = '0;
		endcase
	end

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign busy       = full;
	assign push       = start && !full;
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Store the decoded request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/sfc_back.sv
// ----------------------------------------------------------------------------
// sfc_back: plane store and plane sweep
// Executes queued requests in order. A load writes one plane; a
// test sweeps the stored planes one per cycle through a shared three-stage
// dot-product pipe and folds the sign checks into one result strobe.
// ----------------------------------------------------------------------------
module sfc_back #(
	parameter int NUM_PLANES = sfc_pkg::NUM_PLANES_DEF,
	parameter int FRAC_BITS  = sfc_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  sfc_pkg::entry_t head,
	output logic            pop,
	output logic            done,
	output logic            inside_res
);

	localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_SWEEP = 1'b1;

	sfc_pkg::plane_t planes_q [NUM_PLANES];
	sfc_pkg::plane_t sel;
	logic            state_q;
	logic [IDX_W-1:0] cnt_q;
	logic            last_issue;
	logic            issue;
	logic [IDX_W+sfc_pkg::PIDX_W-1:0] idx_ext;
	logic [IDX_W-1:0] wr_idx;

	// Operands of the test in progress
	logic signed [sfc_pkg::COORD_W-1:0] px_q, py_q, pz_q;
	logic signed [sfc_pkg::ACC_W-1:0]   thr_q;
	logic                               force_q;

	// Pipe stages
	logic                               valid_s1, last_s1, force_s1;
	logic signed [sfc_pkg::PROD_W-1:0]  prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [sfc_pkg::ACC_W-1:0]   dterm_s1;
	logic                               valid_s2, last_s2, force_s2;
	logic signed [sfc_pkg::ACC_W-1:0]   sum_a_s2, sum_b_s2;
	logic signed [sfc_pkg::ACC_W-1:0]   plane_dist;
	logic                               fail_now;
	logic                               fail_acc_q;

	assign issue      = (state_q == ST_SWEEP);
	assign last_issue = issue && (cnt_q == IDX_W'(NUM_PLANES - 1));
	assign pop        = head_valid && (!issue || last_issue);
	assign sel        = planes_q[cnt_q];
	assign idx_ext    = (IDX_W + sfc_pkg::PIDX_W)'(head.idx);
	assign wr_idx     = idx_ext[IDX_W-1:0];

	// Write planes on load requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				planes_q[i] <= '0;
			end
		end else if (pop && !head.is_test && head.idx_ok) begin
			planes_q[wr_idx] <= '{nx: head.a, ny: head.b, nz: head.c, d: head.d};
		end
	end

	// Sequence the plane sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else if (pop && head.is_test) begin
			state_q <= ST_SWEEP;
			cnt_q   <= '0;
		end else if (last_issue) begin
			state_q <= ST_IDLE;
		end else if (issue) begin
			cnt_q <= cnt_q + IDX_W'(1);
		end
	end

	// Latch test operands
	always_ff @(posedge clk) begin
		if (pop && head.is_test) begin
			px_q    <= head.a;
			py_q    <= head.b;
			pz_q    <= head.c;
			thr_q   <= head.thr;
			force_q <= head.force_pass;
		end
	end

	// Stage 1: products and offset minus threshold
	always_ff @(posedge clk) begin
		prod_x_s1 <= $signed(sel.nx) * px_q;
		prod_y_s1 <= $signed(sel.ny) * py_q;
		prod_z_s1 <= $signed(sel.nz) * pz_q;
		dterm_s1  <= (sfc_pkg::ACC_W'($signed(sel.d)) <<< FRAC_BITS) - thr_q;
		last_s1   <= last_issue;
		force_s1  <= force_q;
	end

	// Stage 2: partial sums
	always_ff @(posedge clk) begin
		sum_a_s2 <= sfc_pkg::ACC_W'(prod_x_s1) + sfc_pkg::ACC_W'(prod_y_s1);
		sum_b_s2 <= sfc_pkg::ACC_W'(prod_z_s1) + dterm_s1;
		last_s2  <= last_s1;
		force_s2 <= force_s1;
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	assign plane_dist = sum_a_s2 + sum_b_s2;
	assign fail_now   = plane_dist[sfc_pkg::ACC_W-1] && !force_s2;

	// Fold plane checks and strobe the result on the last plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_acc_q <= 1'b0;
			done       <= 1'b0;
			inside_res <= 1'b0;
		end else begin
			done <= valid_s2 && last_s2;
			if (valid_s2) begin
				if (last_s2) begin
					inside_res <= !(fail_acc_q || fail_now);
					fail_acc_q <= 1'b0;
				end else begin
					fail_acc_q <= fail_acc_q || fail_now;
				end
			end
		end
	end

endmodule

// File: rtl/sphere_frustum_cull_core.sv
// ----------------------------------------------------------------------------
// sphere_frustum_cull_core: six-plane view frustum test for points and spheres
// A load request writes one plane; a test request checks a point or sphere
// against all stored planes and returns one pass/fail strobe.
// ----------------------------------------------------------------------------
// Usage: a request is taken on a clock edge with start high and busy low.
// Loads (command 0) give no result. Tests (command 1) run through the single
// shared dot-product pipe, which evaluates one plane per cycle. Requests go
// through a QUEUE_DEPTH-entry queue, so busy rises only when that queue is
// full. done is a one-cycle strobe: the result must be captured in that
// cycle, there is no way to hold it. Results come back in request order.
// ----------------------------------------------------------------------------
module sphere_frustum_cull_core #(
	parameter int NUM_PLANES  = sfc_pkg::NUM_PLANES_DEF,
	parameter int FRAC_BITS   = sfc_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = sfc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                command,
	input  logic [sfc_pkg::PIDX_W-1:0]          plane_index,
	input  logic signed [sfc_pkg::COORD_W-1:0]  normal_x,
	input  logic signed [sfc_pkg::COORD_W-1:0]  normal_y,
	input  logic signed [sfc_pkg::COORD_W-1:0]  normal_z,
	input  logic signed [sfc_pkg::COORD_W-1:0]  plane_offset,
	input  logic signed [sfc_pkg::COORD_W-1:0]  point_x,
	input  logic signed [sfc_pkg::COORD_W-1:0]  point_y,
	input  logic signed [sfc_pkg::COORD_W-1:0]  point_z,
	input  logic [sfc_pkg::RADIUS_W-1:0]        radius,
	input  logic [sfc_pkg::MODE_W-1:0]          test_mode,
	output logic                                done,
	output logic                                inside_res
);

	logic            head_valid;
	sfc_pkg::entry_t head;
	logic            pop;

	// Decode and queue requests
	sfc_front #(
		.NUM_PLANES (NUM_PLANES),
		.FRAC_BITS  (FRAC_BITS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.plane_index (plane_index),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z),
		.plane_offset(plane_offset),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.radius      (radius),
		.test_mode   (test_mode),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop)
	);

	// Execute loads and plane sweeps
	sfc_back #(
		.NUM_PLANES(NUM_PLANES),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.done      (done),
		.inside_res(inside_res)
	);

endmodule

// File: rtl/sfc_checker.sv
// ----------------------------------------------------------------------------
// sfc_checker: port-level checks for the sphere frustum cull core
// Watches reset behavior, result spacing, busy and unknown values on the top level ports.
// ----------------------------------------------------------------------------
module sfc_checker #(
	parameter int NUM_PLANES = sfc_pkg::NUM_PLANES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic command,
	input logic done,
	input logic inside_res
);

	// Hold outputs quiet while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> (!busy && !done))
		else $error("busy or done asserted during reset");

	// Drop done between results when there is more than one plane
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(NUM_PLANES > 1 && done) |=> !done)
		else $error("results on consecutive cycles");

	// Raise busy only after a request is taken
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted request");

	// Drive a known result with every strobe
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(inside_res))
		else $error("result unknown at strobe");

	// Take a known command with every request
	a_command_known: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> !$isunknown(command))
		else $error("command unknown at accepted request");

endmodule

bind sphere_frustum_cull_core sfc_checker #(.NUM_PLANES(NUM_PLANES)) u_sfc_checker (.*);

// File: tb/tb_sphere_frustum_cull_core.sv
// ----------------------------------------------------------------------------
// tb_sphere_frustum_cull_core: self-checking regression for the frustum cull
// The bench drives load and test requests through the start/busy handshake.
// A scoreboard keeps its own copy of the six planes and works out each test
// outcome from the exact wide plane distance. Each done strobe is compared
// in order against that outcome. Directed corner requests come first. Random
// phases follow, mostly box-shaped frustums probed near their faces, mixed
// with raw noise requests and varying sender idle rates.
// ----------------------------------------------------------------------------
module tb_sphere_frustum_cull_core;
	import sfc_pkg::*;

	localparam int NPLANES = NUM_PLANES_DEF;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam int WIDE = ACC_W + 8;
	localparam int ONE_Q = 1 << FRAC;
	localparam int RESULT_LAG = NPLANES + 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 120;
	localparam int MAX_REPORTS = 10;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic [RADIUS_W-1:0] RADIUS_INF = '1;
	localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

	// One request as seen on the input ports
	typedef struct {
		logic                      cmd;
		logic [PIDX_W-1:0]         idx;
		logic signed [COORD_W-1:0] nx;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] nz;
		logic signed [COORD_W-1:0] d;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic [RADIUS_W-1:0]       rad;
		logic [MODE_W-1:0]         mode;
	} cull_req_t;

	// Plane store, containment prediction and in-order result check
	class cull_tracker;
		plane_t planes [NPLANES];
		bit     expected_inside [$];
		int     n_loads, n_tests, n_inside, n_outside, n_bad;

		function new();
			foreach (planes[i]) planes[i] = '0;
		endfunction

		function bit predict_inside(cull_req_t r);
			logic signed [WIDE-1:0] rad_w, thr, plane_dist;
			logic signed [WIDE-1:0] nx_w, ny_w, nz_w, d_w, px_w, py_w, pz_w;
			if (r.mode == MODE_PARTLY && r.rad == RADIUS_INF)
				return 1'b1;
			rad_w = WIDE'($signed({1'b0, r.rad}));
			rad_w = rad_w <<< FRAC;
			if (r.mode == MODE_FULLY)
				thr = rad_w;
			else if (r.mode == MODE_PARTLY)
				thr = -rad_w;
			else
				thr = '0;
			px_w = WIDE'(r.px);
			py_w = WIDE'(r.py);
			pz_w = WIDE'(r.pz);
			for (int i = 0; i < NPLANES; i++) begin
				nx_w = WIDE'($signed(planes[i].nx));
				ny_w = WIDE'($signed(planes[i].ny));
				nz_w = WIDE'($signed(planes[i].nz));
				d_w  = WIDE'($signed(planes[i].d));
				plane_dist = nx_w * px_w + ny_w * py_w + nz_w * pz_w + (d_w <<< FRAC) - thr;
				if (plane_dist < 0)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_request(cull_req_t r);
			if (r.cmd == CMD_LOAD) begin
				n_loads++;
				if (r.idx < NPLANES) begin
					planes[r.idx].nx = r.nx;
					planes[r.idx].ny = r.ny;
					planes[r.idx].nz = r.nz;
					planes[r.idx].d  = r.d;
				end
			end else begin
				n_tests++;
				expected_inside.push_back(predict_inside(r));
			end
		endfunction

		function void check_result(bit got);
			bit want;
			if (got) n_inside++; else n_outside++;
			if (expected_inside.size() == 0) begin
				n_bad++;
				if (n_bad <= MAX_REPORTS)
					$display("ERROR: result %0b with no test request pending", got);
				return;
			end
			want = expected_inside.pop_front();
			if (got !== want) begin
				n_bad++;
				if (n_bad <= MAX_REPORTS)
					$display("ERROR: inside_res expected %0b actual %0b", want, got);
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      command;
	logic [PIDX_W-1:0]         plane_index;
	logic signed [COORD_W-1:0] normal_x, normal_y, normal_z, plane_offset;
	logic signed [COORD_W-1:0] point_x, point_y, point_z;
	logic [RADIUS_W-1:0]       radius;
	logic [MODE_W-1:0]         test_mode;
	logic                      done;
	logic                      inside_res;

	cull_tracker board = new();
	int cycles = 0;
	int box_half;

	sphere_frustum_cull_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.plane_index  (plane_index),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.plane_offset (plane_offset),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.radius       (radius),
		.test_mode    (test_mode),
		.done         (done),
		.inside_res   (inside_res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Check every result strobe
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(inside_res);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("ERROR: timeout with %0d results outstanding",
				board.expected_inside.size());
			$display("sphere_frustum_cull_core regression: fail");
			$finish;
		end
	end

	// Every field random; callers override what matters
	function automatic cull_req_t noise_request();
		cull_req_t r;
		r.cmd  = 1'($urandom_range(1));
		r.idx  = PIDX_W'($urandom_range(7));
		r.nx   = $urandom;
		r.ny   = $urandom;
		r.nz   = $urandom;
		r.d    = $urandom;
		r.px   = $urandom;
		r.py   = $urandom;
		r.pz   = $urandom;
		r.rad  = RADIUS_W'($urandom);
		r.mode = MODE_W'($urandom_range(3));
		return r;
	endfunction

	// Full range, corner values or small magnitudes
	function automatic logic signed [COORD_W-1:0] pick_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: begin
				case ($urandom_range(4))
					0: return C_MAX;
					1: return C_MIN;
					2: return '0;
					3: return 32'sd1;
					default: return -32'sd1;
				endcase
			end
			default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
		endcase
	endfunction

	function automatic cull_req_t make_load(int idx, int nx, int ny, int nz, int d);
		cull_req_t r;
		r = noise_request();
		r.cmd = CMD_LOAD;
		r.idx = PIDX_W'(idx);
		r.nx = nx;
		r.ny = ny;
		r.nz = nz;
		r.d = d;
		return r;
	endfunction

	function automatic cull_req_t make_test(int px, int py, int pz,
			logic [RADIUS_W-1:0] rad, logic [MODE_W-1:0] mode);
		cull_req_t r;
		r = noise_request();
		r.cmd = CMD_TEST;
		r.px = px;
		r.py = py;
		r.pz = pz;
		r.rad = rad;
		r.mode = mode;
		return r;
	endfunction

	// Present one request and hold it until taken
	task automatic send_request(cull_req_t r);
		start        <= 1'b1;
		command      <= r.cmd;
		plane_index  <= r.idx;
		normal_x     <= r.nx;
		normal_y     <= r.ny;
		normal_z     <= r.nz;
		plane_offset <= r.d;
		point_x      <= r.px;
		point_y      <= r.py;
		point_z      <= r.pz;
		radius       <= r.rad;
		test_mode    <= r.mode;
		do @(posedge clk); while (busy);
		board.note_request(r);
	endtask

	task automatic push(cull_req_t r, int idle_pct);
		send_request(r);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Hold off until every test outcome is back and the pipe is empty
	task automatic drain();
		start <= 1'b0;
		while (board.expected_inside.size() != 0) @(posedge clk);
		repeat (RESULT_LAG) @(posedge clk);
	endtask

	// Load an axis-aligned box of half size box_half around the origin
	task automatic load_box(int idle_pct);
		box_half = $urandom_range(ONE_Q, 1 << 28);
		for (int a = 0; a < 3; a++) begin
			for (int s = 0; s < 2; s++) begin
				int n;
				n = s ? -ONE_Q : ONE_Q;
				push(make_load(2 * a + s, a == 0 ? n : 0, a == 1 ? n : 0,
					a == 2 ? n : 0, box_half), idle_pct);
			end
		end
	endtask

	// Probe near the box faces
	function automatic cull_req_t box_test();
		int span;
		logic [RADIUS_W-1:0] rad;
		span = box_half + box_half / 4;
		case ($urandom_range(19))
			0: rad = RADIUS_INF;
			1: rad = '0;
			default: rad = RADIUS_W'($urandom_range(0, box_half / 2));
		endcase
		return make_test($signed($urandom_range(0, 2 * span)) - span,
			$signed($urandom_range(0, 2 * span)) - span,
			$signed($urandom_range(0, 2 * span)) - span, rad,
			MODE_W'($urandom_range(3)));
	endfunction

	initial begin
		int idle_pct, count, k;
		cull_req_t r;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		command      <= CMD_LOAD;
		plane_index  <= '0;
		normal_x     <= '0;
		normal_y     <= '0;
		normal_z     <= '0;
		plane_offset <= '0;
		point_x      <= '0;
		point_y      <= '0;
		point_z      <= '0;
		radius       <= '0;
		test_mode    <= MODE_POINT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero planes right after reset
		push(make_test(0, 0, 0, '0, MODE_POINT), 0);
		push(make_test(C_MAX, C_MIN, 5, '0, MODE_FULLY), 0);
		push(make_test(0, 0, 0, 1, MODE_FULLY), 0);
		push(make_test(C_MIN, C_MIN, C_MIN, RADIUS_INF, MODE_PARTLY), 0);
		push(make_test(C_MAX, C_MAX, C_MAX, RADIUS_INF, MODE_FULLY), 0);
		push(make_test(1, -1, 0, RADIUS_INF, MODE_SPARE), 0);
		// Loads past the last plane leave the store alone
		push(make_load(6, C_MIN, C_MIN, C_MIN, C_MIN), 0);
		push(make_load(7, -1, -1, -1, -1), 0);
		push(make_test(C_MAX, 0, C_MIN, '0, MODE_FULLY), 0);
		// Extreme planes and points
		push(make_load(0, C_MAX, C_MAX, C_MAX, C_MAX), 0);
		push(make_load(1, C_MIN, C_MIN, C_MIN, C_MIN), 0);
		push(make_load(2, C_MAX, C_MIN, 0, C_MAX), 0);
		push(make_load(3, 0, 0, 0, C_MIN), 0);
		push(make_load(4, 0, 0, 0, C_MAX), 0);
		push(make_load(5, C_MIN, C_MAX, C_MAX, 0), 0);
		push(make_test(C_MIN, C_MIN, C_MIN, '0, MODE_POINT), 0);
		push(make_test(C_MAX, C_MAX, C_MAX, RADIUS_INF, MODE_FULLY), 0);
		push(make_test(C_MIN, C_MAX, C_MIN, RADIUS_INF, MODE_PARTLY), 0);
		push(make_test(C_MIN, C_MAX, C_MIN, RADIUS_INF - 1, MODE_PARTLY), 0);
		push(make_test(0, 0, 0, RADIUS_INF, MODE_SPARE), 0);
		drain();

		// Random phases: no idling, heavy idling, no idling, light idling
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 53 : (ph == 3) ? 25 : 0;
			load_box(idle_pct);
			count = 0;
			while (count < PHASE_ITEMS) begin
				k = $urandom_range(99);
				if (k < 5) begin
					load_box(idle_pct);
					count += 6;
				end else if (k < 15) begin
					r = noise_request();
					r.cmd = CMD_LOAD;
					if (r.idx < NPLANES) count++;
					if ($urandom_range(1)) begin
						r.nx = pick_coord();
						r.ny = pick_coord();
						r.nz = pick_coord();
						r.d  = pick_coord();
					end
					push(r, idle_pct);
				end else if (k < 30) begin
					r = noise_request();
					r.cmd = CMD_TEST;
					r.px = pick_coord();
					r.py = pick_coord();
					r.pz = pick_coord();
					push(r, idle_pct);
					count++;
				end else begin
					push(box_test(), idle_pct);
					count++;
				end
			end
			drain();
		end

		$display("covered %0d plane loads and %0d containment tests", board.n_loads,
			board.n_tests);
		$display("outcomes seen: %0d inside, %0d outside, %0d mismatches", board.n_inside,
			board.n_outside, board.n_bad);
		if (board.n_bad == 0)
			$display("sphere_frustum_cull_core regression: pass");
		else
			$display("sphere_frustum_cull_core regression: fail");
		$finish;
	end

endmodule
